[src/pat_pkg.sv]
// Shared types and constants for the PAT section parser.
package pat_pkg;

   // Default table sizes
   localparam int CHANNEL_DEPTH_DEF = 32;
   localparam int PMT_DEPTH_DEF     = 16;

   // Queue between parser and table unit
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Byte positions within a section
   localparam int          POS_W       = 12;
   localparam logic [11:0] POS_NONE    = 12'd0;
   localparam logic [11:0] POS_LEN_HI  = 12'd1;
   localparam logic [11:0] POS_LEN_LO  = 12'd2;
   localparam logic [11:0] POS_TSID_HI = 12'd3;
   localparam logic [11:0] POS_TSID_LO = 12'd4;
   localparam logic [11:0] POS_ENTRY   = 12'd8;
   localparam logic [11:0] POS_MAX     = 12'd4095;

   // Section length bytes that precede and follow the program loop
   localparam logic [11:0] LEN_OVERHEAD = 12'd9;

   // PID limits
   localparam logic [12:0] PID_MIN     = 13'h0010;
   localparam logic [12:0] PID_LIMIT   = 13'h1fff;
   localparam logic [12:0] PMT_PID_MIN = 13'h0012;

   // Entry byte within a program entry holding the PID low byte
   localparam logic [1:0] ENTRY_LAST_BYTE = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] section_byte;
      logic       section_start;
   } req_type;

   typedef struct packed {
      logic [15:0] transport_id;
      logic [15:0] program_number;
      logic [12:0] pmt_pid;
      logic        new_channel;
      logic        new_pmt;
      logic        table_full;
      logic        invalid_pid;
      logic        last_entry;
   } rsp_type;

   // One unit of work for the table unit
   typedef struct packed {
      logic        clear;
      logic [15:0] transport_id;
      logic [15:0] program_number;
      logic [12:0] pmt_pid;
      logic        invalid_pid;
      logic        last_entry;
   } work_type;

endpackage

[src/pat_front.sv]
// Section byte parser: tracks position, length and tsid and emits program entries.
module pat_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pat_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              push,
   output pat_pkg::work_type push_data
);
   import pat_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [11:0]      len_ff, len_in;
   logic [15:0]      tsid_ff, tsid_in;
   logic             skip_ff, skip_in;
   logic [23:0]      entry_ff, entry_in;

   logic             accept;
   logic [POS_W-1:0] pos_next;
   logic [11:0]      pos_off;
   logic [11:0]      len_off;
   logic [9:0]       entries;
   logic [9:0]       idx;
   logic [1:0]       kbyte;
   logic [12:0]      pid;
   logic             bad;
   logic             last;

   // Stall only when the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Entry bookkeeping
   assign pos_next = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 12'd1;
   assign pos_off  = pos_ff - POS_ENTRY;
   assign len_off  = len_ff - LEN_OVERHEAD;
   assign entries  = (len_ff >= LEN_OVERHEAD) ? len_off[11:2] : 10'd0;
   assign idx      = pos_off[11:2];
   assign kbyte    = pos_off[1:0];
   assign pid      = {entry_ff[4:0], req_data.section_byte};
   assign bad      = (pid < PID_MIN) || (pid >= PID_LIMIT);
   assign last     = ({1'b0, idx} + 11'd1) == {1'b0, entries};

   // Parse one byte
   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      tsid_in  = tsid_ff;
      skip_in  = skip_ff;
      entry_in = entry_ff;
      push     = 1'b0;
      push_data.clear          = 1'b0;
      push_data.transport_id   = tsid_ff;
      push_data.program_number = entry_ff[23:8];
      push_data.pmt_pid        = pid;
      push_data.invalid_pid    = bad;
      push_data.last_entry     = last;
      if (accept) begin
         if (req_data.kind == KIND_CLEAR) begin
            push            = 1'b1;
            push_data.clear = 1'b1;
         end else if (req_data.section_start) begin
            pos_in   = POS_LEN_HI;
            len_in   = 12'd0;
            tsid_in  = 16'd0;
            entry_in = 24'd0;
            skip_in  = (req_data.section_byte != 8'd0);
         end else if (!skip_ff) begin
            case (pos_ff)
               POS_LEN_HI: begin
                  len_in = {req_data.section_byte[3:0], 8'd0};
                  pos_in = pos_next;
               end
               POS_LEN_LO: begin
                  len_in = {len_ff[11:8], req_data.section_byte};
                  pos_in = pos_next;
               end
               POS_TSID_HI: begin
                  tsid_in = {req_data.section_byte, 8'd0};
                  pos_in  = pos_next;
               end
               POS_TSID_LO: begin
                  tsid_in = {tsid_ff[15:8], req_data.section_byte};
                  pos_in  = pos_next;
               end
               default: begin
                  if (pos_ff < POS_ENTRY) begin
                     // reserved header bytes; an unset position drops the section
                     if (pos_ff == POS_NONE) begin
                        skip_in = 1'b1;
                     end else begin
                        pos_in = pos_next;
                     end
                  end else if (idx >= entries) begin
                     skip_in = 1'b1;
                  end else if (kbyte != ENTRY_LAST_BYTE) begin
                     entry_in = (kbyte == 2'd0) ? {16'd0, req_data.section_byte}
                                                : {entry_ff[15:0], req_data.section_byte};
                     pos_in   = pos_next;
                  end else begin
                     push   = 1'b1;
                     pos_in = pos_next;
                     if (bad || last) begin
                        skip_in = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_NONE;
         len_ff   <= 12'd0;
         tsid_ff  <= 16'd0;
         skip_ff  <= 1'b1;
         entry_ff <= 24'd0;
      end else begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         tsid_ff  <= tsid_in;
         skip_ff  <= skip_in;
         entry_ff <= entry_in;
      end
   end

endmodule

[src/pat_queue.sv]
// Short work queue between the parser and the table unit.
module pat_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pat_pkg::work_type push_data,
   output logic              full,
   output logic              head_valid,
   output pat_pkg::work_type head_data,
   input  logic              pop
);
   import pat_pkg::*;

   work_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill level
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/pat_back.sv]
// Table unit: channel and PMT PID lookup and insert, result output register.
module pat_back #(
   parameter int CHANNEL_DEPTH = pat_pkg::CHANNEL_DEPTH_DEF,
   parameter int PMT_DEPTH     = pat_pkg::PMT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pat_pkg::work_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pat_pkg::rsp_type  rsp_data
);
   import pat_pkg::*;

   localparam int CH_CNT_W = $clog2(CHANNEL_DEPTH + 1);
   localparam int PM_CNT_W = $clog2(PMT_DEPTH + 1);

   logic [31:0]         ch_table_ff [CHANNEL_DEPTH];
   logic [12:0]         pm_table_ff [PMT_DEPTH];
   logic [CH_CNT_W-1:0] ch_count_ff, ch_count_in;
   logic [PM_CNT_W-1:0] pm_count_ff, pm_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [31:0] key;
   logic        ch_hit;
   logic        pm_hit;
   logic        ch_room;
   logic        pm_room;
   logic        pid_keep;
   logic        ch_add;
   logic        pm_add;
   logic        full;
   logic        work;

   assign key      = {head_data.transport_id, head_data.program_number};
   assign ch_room  = (ch_count_ff != CH_CNT_W'(CHANNEL_DEPTH));
   assign pm_room  = (pm_count_ff != PM_CNT_W'(PMT_DEPTH));
   assign pid_keep = (head_data.pmt_pid > PMT_PID_MIN);

   // Compare against every filled entry at once
   always_comb begin
      ch_hit = 1'b0;
      for (int i = 0; i < CHANNEL_DEPTH; i++) begin
         if ((CH_CNT_W'(i) < ch_count_ff) && (ch_table_ff[i] == key)) begin
            ch_hit = 1'b1;
         end
      end
      pm_hit = 1'b0;
      for (int i = 0; i < PMT_DEPTH; i++) begin
         if ((PM_CNT_W'(i) < pm_count_ff) && (pm_table_ff[i] == head_data.pmt_pid)) begin
            pm_hit = 1'b1;
         end
      end
   end

   // Decide adds; an invalid PID touches nothing
   assign ch_add = !head_data.invalid_pid && !ch_hit && ch_room;
   assign pm_add = !head_data.invalid_pid && !pm_hit && pid_keep && pm_room;
   assign full   = !head_data.invalid_pid &&
                   ((!ch_hit && !ch_room) || (!pm_hit && pid_keep && !pm_room));

   // Take a clear at once, an entry only when the output register frees up
   assign pop  = head_valid && (head_data.clear || !rsp_valid_ff || !rsp_stall);
   assign work = pop && !head_data.clear;

   always_comb begin
      ch_count_in = ch_count_ff;
      pm_count_in = pm_count_ff;
      if (pop && head_data.clear) begin
         ch_count_in = '0;
         pm_count_in = '0;
      end else if (work) begin
         if (ch_add) begin
            ch_count_in = ch_count_ff + 1'b1;
         end
         if (pm_add) begin
            pm_count_in = pm_count_ff + 1'b1;
         end
      end
   end

   // Hold the result while stalled, load a new one when taken
   assign rsp_valid_in = work || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (work) begin
         rsp_data_in.transport_id   = head_data.transport_id;
         rsp_data_in.program_number = head_data.program_number;
         rsp_data_in.pmt_pid        = head_data.pmt_pid;
         rsp_data_in.new_channel    = ch_add;
         rsp_data_in.new_pmt        = pm_add;
         rsp_data_in.table_full     = full;
         rsp_data_in.invalid_pid    = head_data.invalid_pid;
         rsp_data_in.last_entry     = head_data.last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_count_ff  <= '0;
         pm_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ch_count_ff  <= ch_count_in;
         pm_count_ff  <= pm_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Append new entries at the fill count
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < CHANNEL_DEPTH; i++) begin
         if (work && ch_add && (ch_count_ff == CH_CNT_W'(i))) begin
            ch_table_ff[i] <= key;
         end
      end
      for (int i = 0; i < PMT_DEPTH; i++) begin
         if (work && pm_add && (pm_count_ff == PM_CNT_W'(i))) begin
            pm_table_ff[i] <= head_data.pmt_pid;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/pat_section_program_table.sv]
// Top level of the PAT section parser.
//
// The req channel carries one beat per section byte (kind = byte) or a table
// clear command (kind = clear). Bytes start at the table identifier byte,
// flagged by section_start; sections whose table identifier is not 0 are
// dropped. Each complete four-byte program entry gives one rsp beat with the
// tsid, program number, PMT PID and the channel/PMT table flags.
// One req beat is taken per cycle while req_stall is low. The rsp beat for
// an entry is registered: the edge that accepts its last byte writes the
// entry into the work queue, and the output register is then loaded from
// the table unit, which looks up and inserts one entry per cycle when the
// register is free, comparing against all table entries in parallel.
// A four-entry work queue separates parser and table unit. When rsp_stall is
// high the output register holds its beat, the queue fills, and req_stall
// rises once the queue is full.
// Reset empties both tables (fill counts to zero), clears the output and
// the queue, and leaves the parser ignoring bytes until a section start.
module pat_section_program_table #(
   parameter int CHANNEL_DEPTH = pat_pkg::CHANNEL_DEPTH_DEF,
   parameter int PMT_DEPTH     = pat_pkg::PMT_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pat_pkg::rsp_type rsp_data
);
   import pat_pkg::*;

   logic     push;
   work_type push_data;
   logic     q_full;
   logic     head_valid;
   work_type head_data;
   logic     pop;

   pat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   pat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   pat_back #(
      .CHANNEL_DEPTH (CHANNEL_DEPTH),
      .PMT_DEPTH     (PMT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
